[design/rwlp_pkg.sv]
// Shared types and constants for the row wrap layout placer.
// Used by rwlp_cfg_regs, rwlp_place and row_wrap_layout_placer; no dependencies.
`default_nettype none

package rwlp_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned DIM_W          = 15;
  localparam int unsigned GAP_W          = 16;
  localparam int unsigned LIMIT_W        = 24;
  localparam int unsigned OUT_W          = 24;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 24;
  localparam int unsigned IN_TDATA_W     = 32;
  localparam int unsigned OUT_TDATA_W    = 4 * OUT_W;
  localparam int unsigned OUT_TUSER_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ITEM_GAP  = 2'd0,
    REG_ROW_GAP   = 2'd1,
    REG_ROW_LIMIT = 2'd2
  } cfg_reg_e;

  // effective settings, negative gaps already resolved
  typedef struct packed {
    logic [DIM_W-1:0]   item_gap;
    logic [DIM_W-1:0]   row_gap;
    logic [LIMIT_W-1:0] row_width_limit;
  } cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] pos_x;
    logic [OUT_W-1:0] pos_y;
    logic [OUT_W-1:0] canvas_width;
    logic [OUT_W-1:0] canvas_height;
    logic             wrapped;
    logic             overflow;
    logic             set_done;
  } result_t;

endpackage

`default_nettype wire

[design/row_wrap_layout_placer.sv]
// Row wrap layout placer: next-fit shelf packing of rectangles.
// Input item: width and height on s_axis tdata, end of set on tlast.
// Result item per input: top-left corner and running canvas size on
// m_axis tdata, wrapped/overflow flags on tuser, set end on tlast.
// Configuration: cfg_valid_i/cfg_ready_o write channel, index 0 item gap,
// 1 row gap, 2 row width limit; ready is always high, write while idle.
// Path: an accepted item enters the input register, then the placement
// update loads the result register, which drives the result item.
// Throughput: one item per cycle unless stalled; placement state updates in the
// same cycle the result register loads, so the next item sees it at once.
// Stalls: the result register holds while m_axis_tready is low; one more
// item waits in the input register, then s_axis_tready drops.
// Reset: state clears, item gap 0, row gap -1, row width limit 0.
// Depends on rwlp_pkg, rwlp_cfg_regs and rwlp_place.
`default_nettype none

module row_wrap_layout_placer #(
  parameter int unsigned COORD_BITS = rwlp_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [14:0] item_width, [29:15] item_height, [31:30] zero
  input  wire logic [rwlp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [23:0] pos_x, [47:24] pos_y, [71:48] canvas_width, [95:72] canvas_height
  output logic [rwlp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // [0] wrapped, [1] overflow
  output logic [rwlp_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rwlp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rwlp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rwlp_pkg::*;

  cfg_t             cfg;
  result_t          res;
  result_t          out_res_q;
  logic             in_valid_q, in_valid_d;
  logic [DIM_W-1:0] in_w_q, in_h_q;
  logic             in_last_q;
  logic             out_valid_q, out_valid_d;
  logic             out_adv;
  logic             step;

  rwlp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rwlp_place #(
    .COORD_BITS (COORD_BITS)
  ) u_place (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_width_i  (in_w_q),
    .item_height_i (in_h_q),
    .last_item_i   (in_last_q),
    .step_i        (step),
    .result_o      (res)
  );

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_adv;
  assign s_axis_tready = !in_valid_q || out_adv;

  always_comb begin
    in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
    out_valid_d = out_adv ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_w_q    <= s_axis_tdata[DIM_W-1:0];
      in_h_q    <= s_axis_tdata[2*DIM_W-1:DIM_W];
      in_last_q <= s_axis_tlast;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.canvas_height, out_res_q.canvas_width,
                          out_res_q.pos_y, out_res_q.pos_x};
  assign m_axis_tuser  = {out_res_q.overflow, out_res_q.wrapped};
  assign m_axis_tlast  = out_res_q.set_done;

  // a rectangle that opens a new row sits at the left edge
  a_wrap_left_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[OUT_W-1:0] == '0)
    else $error("wrapped item not at x = 0");

  // input side only blocks with both registers full and the output stalled
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without backpressure");

  // an item in the input register reaches an empty result register next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("item did not advance to result register");

endmodule

`default_nettype wire

[design/rwlp_cfg_regs.sv]
// Configuration registers of the placer: item gap, row gap, row width limit.
// Depends on rwlp_pkg.
`default_nettype none

module rwlp_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rwlp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rwlp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rwlp_pkg::cfg_t                      cfg_o
);
  import rwlp_pkg::*;

  logic [GAP_W-1:0]   item_gap_q, item_gap_d;
  logic [GAP_W-1:0]   row_gap_q, row_gap_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic [DIM_W-1:0]   ig_eff;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    item_gap_d = item_gap_q;
    row_gap_d  = row_gap_q;
    limit_d    = limit_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ITEM_GAP:  item_gap_d = cfg_data_i[GAP_W-1:0];
        REG_ROW_GAP:   row_gap_d  = cfg_data_i[GAP_W-1:0];
        REG_ROW_LIMIT: limit_d    = cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_gap_q <= '0;
      row_gap_q  <= '1;
      limit_q    <= '0;
    end else begin
      item_gap_q <= item_gap_d;
      row_gap_q  <= row_gap_d;
      limit_q    <= limit_d;
    end
  end

  // negative gap counts as zero; negative row gap falls back to item gap
  assign ig_eff = item_gap_q[GAP_W-1] ? '0 : item_gap_q[DIM_W-1:0];

  always_comb begin
    cfg_o.item_gap        = ig_eff;
    cfg_o.row_gap         = row_gap_q[GAP_W-1] ? ig_eff : row_gap_q[DIM_W-1:0];
    cfg_o.row_width_limit = limit_q;
  end

endmodule

`default_nettype wire

[design/rwlp_place.sv]
// Placement state and single pass update: wrap decision, saturating
// coordinate sums and canvas totals. Depends on rwlp_pkg.
`default_nettype none

module rwlp_place #(
  parameter int unsigned COORD_BITS = rwlp_pkg::COORD_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  rwlp_pkg::cfg_t                  cfg_i,
  input  wire logic [rwlp_pkg::DIM_W-1:0] item_width_i,
  input  wire logic [rwlp_pkg::DIM_W-1:0] item_height_i,
  input  wire logic                       last_item_i,
  input  wire logic                       step_i,
  output rwlp_pkg::result_t               result_o
);
  import rwlp_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned SW = (C + 2 > LIMIT_W + 1) ? C + 2 : LIMIT_W + 1;
  localparam int unsigned MW = (C > OUT_W) ? C : OUT_W;

  logic [C:0]       cursor_x_q, cursor_x_d;
  logic [C-1:0]     cursor_y_q, cursor_y_d;
  logic [C-1:0]     row_ext_q, row_ext_d;
  logic [DIM_W-1:0] tallest_q, tallest_d;
  logic [C-1:0]     widest_q, widest_d;
  logic             occupied_q, occupied_d;
  logic             sat_q, sat_d;

  logic [SW-1:0]    reach;
  logic             wrap;
  logic [C+1:0]     y_sum;
  logic             y_sat;
  logic [C:0]       cx_eff;
  logic [C-1:0]     cy_eff;
  logic [C-1:0]     px;
  logic [C+1:0]     ext_sum;
  logic             ext_sat;
  logic [C-1:0]     ext;
  logic [DIM_W-1:0] tall_base, tall_new;
  logic [C-1:0]     widest_eff, cw;
  logic [C:0]       ch_sum;
  logic [C-1:0]     ch;
  logic             sat_new;

  function automatic logic [OUT_W-1:0] fit(input logic [C-1:0] v);
    logic [MW-1:0] t;
    t = MW'(v);
    return t[OUT_W-1:0];
  endfunction

  always_comb begin
    reach = SW'(cursor_x_q) + SW'(item_width_i);
    wrap  = (cfg_i.row_width_limit != '0) && occupied_q &&
            (reach > SW'(cfg_i.row_width_limit));

    y_sum  = (C+2)'(cursor_y_q) + (C+2)'(tallest_q) + (C+2)'(cfg_i.row_gap);
    y_sat  = |y_sum[C+1:C];
    cx_eff = wrap ? '0 : cursor_x_q;
    cy_eff = wrap ? (y_sat ? '1 : y_sum[C-1:0]) : cursor_y_q;

    px = cx_eff[C] ? '1 : cx_eff[C-1:0];

    ext_sum = (C+2)'(cx_eff) + (C+2)'(item_width_i);
    ext_sat = |ext_sum[C+1:C];
    ext     = ext_sat ? '1 : ext_sum[C-1:0];

    tall_base = wrap ? '0 : tallest_q;
    tall_new  = (item_height_i > tall_base) ? item_height_i : tall_base;

    widest_eff = (wrap && (row_ext_q > widest_q)) ? row_ext_q : widest_q;
    cw         = (widest_eff > ext) ? widest_eff : ext;

    ch_sum = (C+1)'(cy_eff) + (C+1)'(tall_new);
    ch     = ch_sum[C] ? '1 : ch_sum[C-1:0];

    sat_new = sat_q | (wrap & y_sat) | cx_eff[C] | ext_sat | ch_sum[C];

    result_o.pos_x         = fit(px);
    result_o.pos_y         = fit(cy_eff);
    result_o.canvas_width  = fit(cw);
    result_o.canvas_height = fit(ch);
    result_o.wrapped       = wrap;
    result_o.overflow      = sat_new;
    result_o.set_done      = last_item_i;
  end

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    row_ext_d  = row_ext_q;
    tallest_d  = tallest_q;
    widest_d   = widest_q;
    occupied_d = occupied_q;
    sat_d      = sat_q;
    if (step_i) begin
      if (last_item_i) begin
        cursor_x_d = '0;
        cursor_y_d = '0;
        row_ext_d  = '0;
        tallest_d  = '0;
        widest_d   = '0;
        occupied_d = 1'b0;
        sat_d      = 1'b0;
      end else begin
        cursor_x_d = (C+1)'(ext) + (C+1)'(cfg_i.item_gap);
        cursor_y_d = cy_eff;
        row_ext_d  = ext;
        tallest_d  = tall_new;
        widest_d   = widest_eff;
        occupied_d = 1'b1;
        sat_d      = sat_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      row_ext_q  <= '0;
      tallest_q  <= '0;
      widest_q   <= '0;
      occupied_q <= 1'b0;
      sat_q      <= 1'b0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      row_ext_q  <= row_ext_d;
      tallest_q  <= tallest_d;
      widest_q   <= widest_d;
      occupied_q <= occupied_d;
      sat_q      <= sat_d;
    end
  end

endmodule

`default_nettype wire
